FILE: hw/rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, controller states and the command/status words that pass
// between the top-K controller and its datapath.
// ----------------------------------------------------------------------------
package knn_pkg;

	localparam int DIST_W  = 32;
	localparam int LABEL_W = 16;
	localparam int VOTE_W  = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_LOAD,
		ST_SCAN,
		ST_NEXT,
		ST_EMIT
	} knn_state_t;

	typedef struct packed {
		logic accept;
		logic insert;
		logic vote_load;
		logic vote_scan;
		logic vote_next;
		logic emit;
	} knn_cmd_t;

	typedef struct packed {
		logic last;
		logic scan_end;
		logic next_end;
		logic out_busy;
	} knn_status_t;

endpackage

FILE: hw/rtl/knn_pair_if.sv
// ----------------------------------------------------------------------------
// knn_pair_if
// Input channel: one (distance, label, last_pair) word per handshake.
// ----------------------------------------------------------------------------
interface knn_pair_if import knn_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [DIST_W-1:0]  distance;
	logic [LABEL_W-1:0] label;
	logic               last_pair;

	modport source (output valid, output distance, output label, output last_pair,
		input ready);
	modport sink (input valid, input distance, input label, input last_pair,
		output ready);
endinterface

FILE: hw/rtl/knn_vote_if.sv
// ----------------------------------------------------------------------------
// knn_vote_if
// Result channel: one (predicted_label, vote_count) word per data set.
// ----------------------------------------------------------------------------
interface knn_vote_if import knn_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] predicted_label;
	logic [VOTE_W-1:0]  vote_count;

	modport source (output valid, output predicted_label, output vote_count,
		input ready);
	modport sink (input valid, input predicted_label, input vote_count,
		output ready);
endinterface

FILE: hw/rtl/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer: takes a word, inserts it, and on the last word of a set runs
// the label vote and hands the result to the output register.
// ----------------------------------------------------------------------------
module knn_ctrl import knn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  knn_status_t status,
	output knn_cmd_t    cmd
);

	knn_state_t state_q;
	knn_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = status.last ? ST_LOAD : ST_IDLE;
			end
			ST_LOAD: begin
				cmd.vote_load = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.vote_scan = 1'b1;
				if (status.scan_end) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.vote_next = 1'b1;
				state_d       = status.next_end ? ST_EMIT : ST_LOAD;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/knn_datapath.sv
// ----------------------------------------------------------------------------
// knn_datapath
// Sorted neighbour store (insertion cells), label rotator with match
// counter for the vote, and the output register.
// ----------------------------------------------------------------------------
module knn_datapath import knn_pkg::*; #(
	parameter int NEIGHBOURS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  knn_cmd_t           cmd,
	output knn_status_t        status,
	input  logic [DIST_W-1:0]  distance,
	input  logic [LABEL_W-1:0] label,
	input  logic               last_pair,
	input  logic               res_ready,
	output logic               res_valid,
	output logic [LABEL_W-1:0] res_label,
	output logic [VOTE_W-1:0]  res_count
);

	localparam int CW = $clog2(NEIGHBOURS + 1);
	localparam int IW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

	// store kept sorted by distance; equal distances newest first, so the
	// top slot is always the largest and oldest entry
	logic [DIST_W-1:0]  dist_q [NEIGHBOURS];
	logic [DIST_W-1:0]  dist_d [NEIGHBOURS];
	logic [LABEL_W-1:0] lab_q  [NEIGHBOURS];
	logic [LABEL_W-1:0] lab_d  [NEIGHBOURS];
	logic [NEIGHBOURS-1:0] lt_d;
	logic [NEIGHBOURS-1:0] lt_q;
	logic               drop_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      last_idx;
	logic [DIST_W-1:0]  new_dist_q;
	logic [LABEL_W-1:0] new_lab_q;
	logic               last_q;
	logic [LABEL_W-1:0] cand_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      best_cnt_q;
	logic [LABEL_W-1:0] best_lab_q;
	logic [IW-1:0]      j_q;
	logic [IW-1:0]      k_q;
	logic               res_valid_q;
	logic [LABEL_W-1:0] res_label_q;
	logic [VOTE_W-1:0]  res_count_q;

	assign last_idx = count_q - CW'(1);

	always_comb begin
		for (int i = 0; i < NEIGHBOURS; i++) begin
			lt_d[i] = (CW'(i) < count_q) && (dist_q[i] < distance);
		end
	end

	always_comb begin
		for (int i = 0; i < NEIGHBOURS; i++) begin
			dist_d[i] = dist_q[i];
			lab_d[i]  = lab_q[i];
		end
		if (cmd.insert && !drop_q) begin
			if (!lt_q[0]) begin
				dist_d[0] = new_dist_q;
				lab_d[0]  = new_lab_q;
			end
			for (int i = 1; i < NEIGHBOURS; i++) begin
				if (!lt_q[i]) begin
					if (lt_q[i-1]) begin
						dist_d[i] = new_dist_q;
						lab_d[i]  = new_lab_q;
					end else begin
						dist_d[i] = dist_q[i-1];
						lab_d[i]  = lab_q[i-1];
					end
				end
			end
		end else if (cmd.vote_scan || cmd.vote_next) begin
			// rotate the valid labels by one slot
			for (int i = 0; i < NEIGHBOURS - 1; i++) begin
				if (CW'(i) == last_idx) begin
					lab_d[i] = lab_q[0];
				end else begin
					lab_d[i] = lab_q[i+1];
				end
			end
			if (CW'(NEIGHBOURS - 1) == last_idx) begin
				lab_d[NEIGHBOURS-1] = lab_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NEIGHBOURS; i++) begin
			dist_q[i] <= dist_d[i];
			lab_q[i]  <= lab_d[i];
		end
		if (cmd.accept) begin
			new_dist_q <= distance;
			new_lab_q  <= label;
			last_q     <= last_pair;
			lt_q       <= lt_d;
			// full store: a word no nearer than the top slot is dropped
			drop_q     <= (count_q == CW'(NEIGHBOURS)) &&
				(dist_q[NEIGHBOURS-1] <= distance);
			best_cnt_q <= '0;
			best_lab_q <= '0;
			k_q        <= '0;
		end
		if (cmd.vote_load) begin
			cand_q <= lab_q[0];
			cnt_q  <= '0;
			j_q    <= '0;
		end
		if (cmd.vote_scan) begin
			if (lab_q[0] == cand_q) begin
				cnt_q <= cnt_q + CW'(1);
			end
			j_q <= j_q + IW'(1);
		end
		if (cmd.vote_next) begin
			if ((cnt_q > best_cnt_q) || ((cnt_q == best_cnt_q) && (cand_q < best_lab_q))) begin
				best_cnt_q <= cnt_q;
				best_lab_q <= cand_q;
			end
			k_q <= k_q + IW'(1);
		end
		if (cmd.emit) begin
			res_label_q <= best_lab_q;
			res_count_q <= VOTE_W'(best_cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				count_q <= '0;
			end else if (cmd.insert && (count_q != CW'(NEIGHBOURS))) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign status.last     = last_q;
	assign status.scan_end = (CW'(j_q) == last_idx);
	assign status.next_end = (CW'(k_q) == last_idx);
	assign status.out_busy = res_valid_q && !res_ready;

	assign res_valid = res_valid_q;
	assign res_label = res_label_q;
	assign res_count = res_count_q;

endmodule

FILE: hw/rtl/knn_topk_majority_vote.sv
// ----------------------------------------------------------------------------
// knn_topk_majority_vote
// Keeps the NEIGHBOURS nearest (distance, label) pairs of a data set and
// returns the majority label of those neighbours on the set's last word.
// ----------------------------------------------------------------------------
// Usage:
//   pair : one (distance, label, last_pair) word per handshake. Each word
//          is latched and compared against every kept distance in parallel,
//          then shifted into the sorted store; pair is not ready meanwhile.
//   vote : one (predicted_label, vote_count) word per data set, ties going
//          to the smallest label.
//   On a word with last_pair set, the vote follows the insertion. It runs
//   through the label store with a single compare, rotating the labels;
//   each kept label is counted in turn, then the best one is loaded into
//   the output register. pair is not ready during the vote.
//   The result waits in the output register while the sink stalls; new
//   words are taken meanwhile, and only the next vote's hand-off waits.
//   Reset empties the store and drops any pending result.
// ----------------------------------------------------------------------------
module knn_topk_majority_vote import knn_pkg::*; #(
	parameter int NEIGHBOURS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	knn_pair_if.sink   pair,
	knn_vote_if.source vote
);

	knn_cmd_t    cmd;
	knn_status_t status;

	knn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pair.valid),
		.in_ready (pair.ready),
		.status   (status),
		.cmd      (cmd)
	);

	knn_datapath #(
		.NEIGHBOURS (NEIGHBOURS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.distance  (pair.distance),
		.label     (pair.label),
		.last_pair (pair.last_pair),
		.res_ready (vote.ready),
		.res_valid (vote.valid),
		.res_label (vote.predicted_label),
		.res_count (vote.vote_count)
	);

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for knn_topk_majority_vote. A short table of directed
// data sets covers field extremes, the tied vote, eviction among equal
// largest distances and dropping of equal distances. Random data sets follow,
// under three pacing regimes and one long result stall. Random votes are
// checked against a behavioural top-K keeper and label counter in the bench.
// ----------------------------------------------------------------------------
module tb import knn_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NEIGHBOURS  = 16;
	localparam int RAND_PAIRS  = 1228;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [VOTE_W-1:0]  count_t;

	typedef struct packed {
		label_t label;
		count_t count;
	} vote_t;

	typedef enum {PACE_SRC_GAPS, PACE_SNK_GAPS, PACE_FREE} pace_t;
	typedef enum {SP_NARROW, SP_WIDE, SP_EDGE} spread_t;

	typedef struct {
		dist_t  distance;
		label_t label;
		bit     fin;
		int     reps;
		bit     typed;
		label_t want_label;
		count_t want_count;
	} dir_row_t;

	localparam int DIR_ROWS = 8;
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{32'h0000_0000, 16'h0000, 1'b1,  1, 1'b1, 16'h0000, 7'd1},
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b1,  1, 1'b1, 16'hFFFF, 7'd1},
		'{32'd10,        16'd5,    1'b0,  1, 1'b0, 16'h0000, 7'd0},
		'{32'd20,        16'd3,    1'b1,  1, 1'b1, 16'd3,    7'd1},
		'{32'hFFFF_FFFF, 16'd1,    1'b0,  1, 1'b0, 16'h0000, 7'd0},
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 15, 1'b0, 16'h0000, 7'd0},
		'{32'hFFFF_FFFF, 16'd0,    1'b0,  1, 1'b0, 16'h0000, 7'd0},
		'{32'h0000_0000, 16'd2,    1'b1,  1, 1'b1, 16'hFFFF, 7'd15}
	};

	logic clk = 1'b0;
	logic arst_n;

	knn_pair_if pair_ch ();
	knn_vote_if vote_ch ();

	knn_topk_majority_vote #(
		.NEIGHBOURS(NEIGHBOURS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.vote   (vote_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// behavioural neighbour store
	dist_t  near_dist [NEIGHBOURS];
	label_t near_label [NEIGHBOURS];
	int     near_cnt;

	vote_t  votes_due [$];
	pace_t  pace;
	int     pairs_sent;
	int     sets_sent;
	int     votes_checked;
	int     full_votes;
	int     mismatches;
	bit     failed;

	function automatic bit keep_and_vote(input dist_t d, input label_t l, input bit fin,
		output vote_t res);
		int     worst;
		int     hits;
		int     best_n;
		label_t best_l;
		res = '0;
		if (near_cnt < NEIGHBOURS) begin
			near_dist[near_cnt]  = d;
			near_label[near_cnt] = l;
			near_cnt++;
		end else begin
			worst = 0;
			for (int i = 1; i < NEIGHBOURS; i++)
				if (near_dist[i] > near_dist[worst])
					worst = i;
			if (d < near_dist[worst]) begin
				for (int i = worst; i < NEIGHBOURS - 1; i++) begin
					near_dist[i]  = near_dist[i + 1];
					near_label[i] = near_label[i + 1];
				end
				near_dist[NEIGHBOURS - 1]  = d;
				near_label[NEIGHBOURS - 1] = l;
			end
		end
		if (!fin)
			return 1'b0;
		if (near_cnt == NEIGHBOURS)
			full_votes++;
		best_n = 0;
		best_l = '0;
		for (int i = 0; i < near_cnt; i++) begin
			hits = 0;
			for (int j = 0; j < near_cnt; j++)
				if (near_label[j] == near_label[i])
					hits++;
			if (hits > best_n || (hits == best_n && near_label[i] < best_l)) begin
				best_n = hits;
				best_l = near_label[i];
			end
		end
		near_cnt  = 0;
		res.label = best_l;
		res.count = count_t'(best_n);
		return 1'b1;
	endfunction

	function automatic void note_mismatch(input string what, input longint want,
		input longint got);
		failed = 1'b1;
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t vote %0d: %s expected 0x%0h, got 0x%0h",
				$time, votes_checked, what, want, got);
	endfunction

	function automatic void check_vote(input label_t got_l, input count_t got_n);
		vote_t want;
		if (votes_due.size() == 0) begin
			note_mismatch("unexpected word, label", 0, got_l);
			return;
		end
		want = votes_due.pop_front();
		votes_checked++;
		if (got_l !== want.label)
			note_mismatch("predicted_label", want.label, got_l);
		if (got_n !== want.count)
			note_mismatch("vote_count", want.count, got_n);
	endfunction

	function automatic dist_t pick_dist(input spread_t sp);
		case (sp)
			SP_NARROW: return dist_t'($urandom_range(7));
			SP_WIDE:   return dist_t'($urandom);
			default: begin
				case ($urandom_range(3))
					0:       return 32'h0000_0000;
					1:       return 32'h0000_0001;
					2:       return 32'hFFFF_FFFE;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic label_t pick_label(input spread_t sp);
		case (sp)
			SP_NARROW: return label_t'($urandom_range(3));
			SP_WIDE:   return label_t'($urandom);
			default:   return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	function automatic spread_t pick_spread();
		int r;
		r = $urandom_range(99);
		return r < 40 ? SP_NARROW : r < 85 ? SP_WIDE : SP_EDGE;
	endfunction

	// one word on the pair channel; typed expectation overrides the predictor
	task automatic send_word(input dist_t d, input label_t l, input bit fin,
		input bit typed = 1'b0, input vote_t typed_vote = '0);
		int    gap_pct;
		vote_t res;
		gap_pct = pace == PACE_SRC_GAPS ? 28 : pace == PACE_SNK_GAPS ? 70 : 0;
		while ($urandom_range(99) < gap_pct) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid     <= 1'b1;
		pair_ch.distance  <= d;
		pair_ch.label     <= l;
		pair_ch.last_pair <= fin;
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
		pairs_sent++;
		if (keep_and_vote(d, l, fin, res)) begin
			sets_sent++;
			votes_due.push_back(typed ? typed_vote : res);
		end
	endtask

	task automatic wait_drained();
		pair_ch.valid <= 1'b0;
		@(posedge clk);
		while (votes_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_set(inout int sent);
		int      len;
		int      r;
		spread_t d_sp;
		spread_t l_sp;
		r = $urandom_range(99);
		len = r < 70 ? $urandom_range(20, 1) : r < 95 ? $urandom_range(40, 17) :
			$urandom_range(80, 41);
		d_sp = pick_spread();
		l_sp = pick_spread();
		for (int k = 0; k < len; k++) begin
			// the odd word strays from the set's spread
			send_word(pick_dist($urandom_range(9) == 0 ? pick_spread() : d_sp),
				pick_label($urandom_range(9) == 0 ? pick_spread() : l_sp),
				k == len - 1);
			sent++;
		end
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		int hold_left;
		bit held;
		int stall_pct;
		hold_left = 0;
		held      = 1'b0;
		vote_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && vote_ch.valid && vote_ch.ready)
				check_vote(vote_ch.predicted_label, vote_ch.vote_count);
			if (!held && pace == PACE_FREE) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			stall_pct = pace == PACE_SRC_GAPS ? 70 : pace == PACE_SNK_GAPS ? 28 : 0;
			if (hold_left > 0) begin
				hold_left--;
				vote_ch.ready <= 1'b0;
			end else begin
				vote_ch.ready <= $urandom_range(99) >= stall_pct;
			end
		end
	end

	initial begin
		int    rand_sent;
		vote_t typed_vote;
		near_cnt      = 0;
		pairs_sent    = 0;
		sets_sent     = 0;
		votes_checked = 0;
		full_votes    = 0;
		mismatches    = 0;
		failed        = 1'b0;
		rand_sent     = 0;
		pace          = PACE_SRC_GAPS;
		arst_n            <= 1'b0;
		pair_ch.valid     <= 1'b0;
		pair_ch.distance  <= '0;
		pair_ch.label     <= '0;
		pair_ch.last_pair <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r]) begin
			typed_vote.label = dir_tab[r].want_label;
			typed_vote.count = dir_tab[r].want_count;
			for (int k = 0; k < dir_tab[r].reps; k++)
				send_word(dir_tab[r].distance, dir_tab[r].label,
					dir_tab[r].fin && k == dir_tab[r].reps - 1,
					dir_tab[r].typed, typed_vote);
		end
		wait_drained();

		while (rand_sent < RAND_PAIRS) begin
			if (pace == PACE_SRC_GAPS && rand_sent >= RAND_PAIRS / 3) begin
				pace = PACE_SNK_GAPS;
			end else if (pace == PACE_SNK_GAPS && rand_sent >= 2 * RAND_PAIRS / 3) begin
				wait_drained();
				pace = PACE_FREE;
			end
			send_set(rand_sent);
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d pairs in %0d data sets, %0d votes checked, %0d on a full store",
			pairs_sent, sets_sent, votes_checked, full_votes);
		$display("run: %0d mismatches", mismatches);
		if (!failed && votes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("run: timed out with %0d votes outstanding", votes_due.size());
		$display("tb: failure");
		$finish;
	end

endmodule
